FILE: rtl/csr_sparse_matvec_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the sparse matrix-vector block.
// The clock is clk and the reset is arst_n in every module that uses them.
// ----------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATVEC_DEFINES_SVH
`define CSR_SPARSE_MATVEC_DEFINES_SVH
`ifndef SYNTH
`define CSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define CSM_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CSM_ASSERT(lbl, prop, msg)
`define CSM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Sizes, item types and floating-point unit request types of the CSR
// sparse matrix-vector block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package csm_pkg;
	localparam int ROW_MAX     = 1024;
	localparam int NONZERO_MAX = 4096;

	localparam int KIND_W      = 2;
	localparam int INDEX_W     = 12;
	localparam int ROW_START_W = 13;
	localparam int COLUMN_W    = 10;
	localparam int VALUE_W     = 64;
	localparam int ROW_W       = 10;
	localparam int RC_W        = 11;

	localparam int RP_AW  = $clog2(ROW_MAX + 1);
	localparam int NZ_AW  = $clog2(NONZERO_MAX);
	localparam int VEC_AW = $clog2(ROW_MAX);
	localparam int PTR_W  = ROW_START_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int Q_AW        = $clog2(QUEUE_DEPTH);

	typedef enum logic [KIND_W-1:0] {
		KIND_ROW_PTR = 2'd0,
		KIND_NONZERO = 2'd1,
		KIND_VECTOR  = 2'd2,
		KIND_COMPUTE = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [INDEX_W-1:0]     index;
		logic [ROW_START_W-1:0] row_start;
		logic [COLUMN_W-1:0]    column;
		logic [VALUE_W-1:0]     value;
	} item_t;

	typedef enum logic {
		FP_MUL = 1'b0,
		FP_ADD = 1'b1
	} fp_op_t;

	typedef struct packed {
		fp_op_t             op;
		logic [VALUE_W-1:0] a;
		logic [VALUE_W-1:0] b;
	} fp_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [VALUE_W-1:0] result;
	} fp_rsp_t;

	// Row pointers past the nonzero store saturate at its end.
	function automatic logic [PTR_W-1:0] clamp_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] lim;
		lim = PTR_W'(NONZERO_MAX);
		return (p > lim) ? lim : p;
	endfunction
endpackage

FILE: rtl/csm_if.sv
// ----------------------------------------------------------------------------
// csm channel interfaces
// Valid/ready channels for input items, result items and the row count write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface csm_req_if import csm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KIND_W-1:0]      kind;
	logic [INDEX_W-1:0]     index;
	logic [ROW_START_W-1:0] row_start;
	logic [COLUMN_W-1:0]    column;
	logic [VALUE_W-1:0]     value;
	modport source (output valid, kind, index, row_start, column, value, input ready);
	modport sink (input valid, kind, index, row_start, column, value, output ready);
endinterface

interface csm_rsp_if import csm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ROW_W-1:0]   row;
	logic [VALUE_W-1:0] row_product;
	modport source (output valid, row, row_product, input ready);
	modport sink (input valid, row, row_product, output ready);
endinterface

interface csm_cfg_if import csm_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [RC_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/csm_front.sv
// ----------------------------------------------------------------------------
// csm_front
// Accepts input items, drops out-of-range writes and unused-row computes,
// and holds the row count register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module csm_front import csm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	csm_req_if.sink         req,
	csm_cfg_if.sink         cfg,
	input  logic            q_full,
	output logic            push,
	output item_t           push_item,
	output logic [RC_W-1:0] row_count
);
	logic [RC_W-1:0] row_count_q;
	logic            keep;

	assign cfg.ready = 1'b1;
	assign req.ready = !q_full;
	assign row_count = row_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= RC_W'(1);
		end else if (cfg.valid) begin
			priority if (cfg.data == '0) begin
				row_count_q <= RC_W'(1);
			end else if (cfg.data > RC_W'(ROW_MAX)) begin
				row_count_q <= RC_W'(ROW_MAX);
			end else begin
				row_count_q <= cfg.data;
			end
		end
	end

	always_comb begin
		unique case (kind_t'(req.kind))
			KIND_ROW_PTR: keep = 32'(req.index) <= 32'(ROW_MAX);
			KIND_NONZERO: keep = 32'(req.index) < 32'(NONZERO_MAX);
			KIND_VECTOR:  keep = 32'(req.index) < 32'(ROW_MAX);
			KIND_COMPUTE: keep = 32'(req.index) < 32'(row_count_q);
			default:      keep = 1'b0;
		endcase
	end

	assign push                = req.valid && req.ready && keep;
	assign push_item.kind      = kind_t'(req.kind);
	assign push_item.index     = req.index;
	assign push_item.row_start = req.row_start;
	assign push_item.column    = req.column;
	assign push_item.value     = req.value;
endmodule

FILE: rtl/csm_queue.sv
// ----------------------------------------------------------------------------
// csm_queue
// Short in-order queue of classified items between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module csm_queue import csm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  empty,
	output logic  full
);
	item_t           slot_q [QUEUE_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (Q_AW+1)'(QUEUE_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (Q_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (Q_AW+1)'(1);
			end
		end
	end
endmodule

FILE: rtl/csm_fpu.sv
// ----------------------------------------------------------------------------
// csm_fpu
// Iterative double-precision multiply and add, round to nearest even,
// with subnormals and x86-style NaN propagation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module csm_fpu import csm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  fp_req_t req,
	output fp_rsp_t rsp
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL    = 3'd1;
	localparam logic [2:0] S_ALIGN  = 3'd2;
	localparam logic [2:0] S_ADDSUB = 3'd3;
	localparam logic [2:0] S_NORM   = 3'd4;
	localparam logic [2:0] S_ROUND  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	localparam logic [63:0] QNAN_DEFAULT = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;
	localparam logic [10:0] EXP_ALL      = 11'h7FF;

	logic [2:0]          state_q;
	logic [63:0]         res_q;
	logic                sign_q;
	logic                sb_q;
	logic signed [13:0]  t_q;
	logic [106:0]        m_q;
	logic [106:0]        ms_q;
	logic                stk_q;
	logic [52:0]         ma_q;
	logic [52:0]         mb_q;
	logic [10:0]         d_q;
	logic [2:0]          step_q;
	logic [53:0]         pp_q;

	// operand unpack
	logic        sa, sb;
	logic [10:0] ea_raw, eb_raw, ea, eb;
	logic [51:0] fa, fb;
	logic [52:0] ma, mb;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic        spec_hit;
	logic [63:0] spec_res;

	always_comb begin
		sa     = req.a[63];
		sb     = req.b[63];
		ea_raw = req.a[62:52];
		eb_raw = req.b[62:52];
		fa     = req.a[51:0];
		fb     = req.b[51:0];
		a_nan  = (ea_raw == EXP_ALL) && (fa != '0);
		b_nan  = (eb_raw == EXP_ALL) && (fb != '0);
		a_inf  = (ea_raw == EXP_ALL) && (fa == '0);
		b_inf  = (eb_raw == EXP_ALL) && (fb == '0);
		a_zero = (ea_raw == '0) && (fa == '0);
		b_zero = (eb_raw == '0) && (fb == '0);
		ma     = {ea_raw != '0, fa};
		mb     = {eb_raw != '0, fb};
		ea     = (ea_raw == '0) ? 11'd1 : ea_raw;
		eb     = (eb_raw == '0) ? 11'd1 : eb_raw;

		spec_hit = 1'b1;
		spec_res = '0;
		priority if (a_nan) begin
			spec_res = req.a | QUIET_BIT;
		end else if (b_nan) begin
			spec_res = req.b | QUIET_BIT;
		end else if (req.op == FP_MUL) begin
			priority if ((a_inf && b_zero) || (a_zero && b_inf)) begin
				spec_res = QNAN_DEFAULT;
			end else if (a_inf || b_inf) begin
				spec_res = {sa ^ sb, EXP_ALL, 52'd0};
			end else if (a_zero || b_zero) begin
				spec_res = {sa ^ sb, 63'd0};
			end else begin
				spec_hit = 1'b0;
			end
		end else begin
			priority if (a_inf && b_inf && (sa != sb)) begin
				spec_res = QNAN_DEFAULT;
			end else if (a_inf) begin
				spec_res = req.a;
			end else if (b_inf) begin
				spec_res = req.b;
			end else if (a_zero && b_zero) begin
				spec_res = {sa & sb, 63'd0};
			end else if (a_zero) begin
				spec_res = req.b;
			end else if (b_zero) begin
				spec_res = req.a;
			end else begin
				spec_hit = 1'b0;
			end
		end
	end

	// one 27x27 partial product per cycle
	logic [26:0]  mul_x, mul_y;
	logic [53:0]  mul_out;
	logic [106:0] pp_ext;

	always_comb begin
		mul_x   = step_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		mul_y   = step_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		mul_out = mul_x * mul_y;
		unique case (step_q)
			3'd2, 3'd3: pp_ext = {53'd0, pp_q} << 27;
			3'd4:       pp_ext = {53'd0, pp_q} << 54;
			default:    pp_ext = {53'd0, pp_q};
		endcase
	end

	// align the smaller addend, fold shifted-out bits into a sticky lsb
	logic [105:0] wide, narrow;
	logic         lost;
	logic [106:0] ms;

	always_comb begin
		wide = {mb_q, 53'd0};
		if (d_q >= 11'd106) begin
			narrow = '0;
			lost   = 1'b1;
		end else begin
			narrow = wide >> d_q;
			lost   = |(wide & ~({106{1'b1}} << d_q));
		end
		ms = {1'b0, narrow[105:1], narrow[0] | lost};
	end

	logic [106:0] sum_ab, diff_ab, diff_ba;
	assign sum_ab  = m_q + ms_q;
	assign diff_ab = m_q - ms_q;
	assign diff_ba = ms_q - m_q;

	// rounding
	logic [52:0]        mant;
	logic               guard, sticky, round_up;
	logic [53:0]        m54;
	logic [52:0]        mant2;
	logic signed [13:0] t2;
	logic [63:0]        rounded;

	always_comb begin
		mant     = m_q[105:53];
		guard    = m_q[52];
		sticky   = (|m_q[51:0]) | stk_q;
		round_up = guard && (sticky || mant[0]);
		m54      = {1'b0, mant} + {53'd0, round_up};
		t2       = t_q + (m54[53] ? 14'sd1 : 14'sd0);
		mant2    = m54[53] ? m54[53:1] : m54[52:0];
		if (t2 >= 14'sd2047) begin
			rounded = {sign_q, EXP_ALL, 52'd0};
		end else begin
			rounded = {sign_q, mant2[52] ? t2[10:0] : 11'd0, mant2[51:0]};
		end
	end

	assign rsp.busy   = (state_q != S_IDLE);
	assign rsp.done   = (state_q == S_DONE);
	assign rsp.result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						stk_q  <= 1'b0;
						step_q <= '0;
						if (spec_hit) begin
							res_q   <= spec_res;
							state_q <= S_DONE;
						end else if (req.op == FP_MUL) begin
							ma_q    <= ma;
							mb_q    <= mb;
							sign_q  <= sa ^ sb;
							t_q     <= $signed({3'b0, ea}) + $signed({3'b0, eb}) - 14'sd1022;
							m_q     <= '0;
							state_q <= S_MUL;
						end else begin
							if (ea >= eb) begin
								ma_q   <= ma;
								mb_q   <= mb;
								sign_q <= sa;
								sb_q   <= sb;
								t_q    <= $signed({3'b0, ea});
								d_q    <= ea - eb;
							end else begin
								ma_q   <= mb;
								mb_q   <= ma;
								sign_q <= sb;
								sb_q   <= sa;
								t_q    <= $signed({3'b0, eb});
								d_q    <= eb - ea;
							end
							state_q <= S_ALIGN;
						end
					end
				end
				S_MUL: begin
					pp_q <= mul_out;
					if (step_q != '0) begin
						m_q <= m_q + pp_ext;
					end
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) begin
						state_q <= S_NORM;
					end
				end
				S_ALIGN: begin
					m_q     <= {1'b0, ma_q, 53'd0};
					ms_q    <= ms;
					state_q <= S_ADDSUB;
				end
				S_ADDSUB: begin
					if (sign_q == sb_q) begin
						m_q <= sum_ab;
					end else if (m_q >= ms_q) begin
						m_q <= diff_ab;
						if (m_q == ms_q) begin
							sign_q <= 1'b0;
						end
					end else begin
						m_q    <= diff_ba;
						sign_q <= sb_q;
					end
					state_q <= S_NORM;
				end
				S_NORM: begin
					priority if (m_q[106]) begin
						m_q   <= m_q >> 1;
						stk_q <= stk_q | m_q[0];
						t_q   <= t_q + 14'sd1;
					end else if (m_q == '0) begin
						state_q <= S_ROUND;
					end else if (t_q < 14'sd1) begin
						if (t_q < -14'sd120) begin
							stk_q <= 1'b1;
							m_q   <= '0;
							t_q   <= 14'sd1;
						end else begin
							m_q   <= m_q >> 1;
							stk_q <= stk_q | m_q[0];
							t_q   <= t_q + 14'sd1;
						end
					end else if (!m_q[105] && (t_q > 14'sd1)) begin
						if ((m_q[105:90] == '0) && (t_q > 14'sd16)) begin
							m_q <= m_q << 16;
							t_q <= t_q - 14'sd16;
						end else begin
							m_q <= m_q << 1;
							t_q <= t_q - 14'sd1;
						end
					end else begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					res_q   <= rounded;
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: rtl/csm_back.sv
// ----------------------------------------------------------------------------
// csm_back
// Owns the row pointer, nonzero and vector stores, carries out queued writes
// and walks one row's nonzeros through the floating-point unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "csr_sparse_matvec_defines.svh"
module csm_back import csm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  item_t           head,
	input  logic            q_empty,
	output logic            q_pop,
	input  logic [RC_W-1:0] row_count,
	csm_rsp_if.source       rsp
);
	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_RP0  = 4'd1;
	localparam logic [3:0] B_RP1  = 4'd2;
	localparam logic [3:0] B_NZ   = 4'd3;
	localparam logic [3:0] B_NZW  = 4'd4;
	localparam logic [3:0] B_VW   = 4'd5;
	localparam logic [3:0] B_MUL  = 4'd6;
	localparam logic [3:0] B_ADDS = 4'd7;
	localparam logic [3:0] B_ADD  = 4'd8;
	localparam logic [3:0] B_EMIT = 4'd9;

	typedef struct packed {
		logic [COLUMN_W-1:0] column;
		logic [VALUE_W-1:0]  value;
	} nz_t;

	logic [ROW_START_W-1:0] rp_mem  [ROW_MAX+1];
	nz_t                    nz_mem  [NONZERO_MAX];
	logic [VALUE_W-1:0]     vec_mem [ROW_MAX];

	logic [ROW_START_W-1:0] rp_rd_q;
	nz_t                    nz_rd_q;
	logic [VALUE_W-1:0]     vec_rd_q;
	logic [RP_AW-1:0]       rp_raddr;

	logic [3:0]         state_q;
	logic [ROW_W-1:0]   row_q;
	logic [PTR_W-1:0]   first_q;
	logic [PTR_W-1:0]   last_q;
	logic [PTR_W-1:0]   j_q;
	logic [VALUE_W-1:0] sum_q;
	logic [VALUE_W-1:0] prod_q;
	logic               ov_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [VALUE_W-1:0] out_prod_q;

	logic             fpu_start;
	fp_req_t          fpu_req;
	fp_rsp_t          fpu_rsp;
	logic [PTR_W-1:0] last_ptr;
	logic             last_nz;
	logic             col_used;

	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign rp_raddr = (state_q == B_IDLE) ? head.index[RP_AW-1:0]
	                                      : RP_AW'(row_q) + RP_AW'(1);
	assign last_ptr = clamp_ptr(rp_rd_q);
	assign last_nz  = (j_q + PTR_W'(1)) >= last_q;
	assign col_used = RC_W'(nz_rd_q.column) < row_count;

	// stores: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (q_pop && (head.kind == KIND_ROW_PTR)) begin
			rp_mem[head.index[RP_AW-1:0]] <= head.row_start;
		end
		rp_rd_q <= rp_mem[rp_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop && (head.kind == KIND_NONZERO)) begin
			nz_mem[head.index[NZ_AW-1:0]] <= '{column: head.column, value: head.value};
		end
		nz_rd_q <= nz_mem[j_q[NZ_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_pop && (head.kind == KIND_VECTOR)) begin
			vec_mem[head.index[VEC_AW-1:0]] <= head.value;
		end
		vec_rd_q <= vec_mem[nz_rd_q.column[VEC_AW-1:0]];
	end

	always_comb begin
		fpu_start = 1'b0;
		fpu_req   = '{op: FP_MUL, a: nz_rd_q.value, b: vec_rd_q};
		unique case (state_q)
			B_VW: begin
				fpu_start = 1'b1;
			end
			B_ADDS: begin
				fpu_start = 1'b1;
				fpu_req   = '{op: FP_ADD, a: sum_q, b: prod_q};
			end
			default: begin
				fpu_start = 1'b0;
			end
		endcase
	end

	csm_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fpu_start),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
		end else begin
			// load a new result or drop the one just taken
			if ((state_q == B_EMIT) && (!ov_q || rsp.ready)) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_pop && (head.kind == KIND_COMPUTE)) begin
						row_q   <= head.index[ROW_W-1:0];
						state_q <= B_RP0;
					end
				end
				B_RP0: begin
					first_q <= clamp_ptr(rp_rd_q);
					state_q <= B_RP1;
				end
				B_RP1: begin
					sum_q  <= '0;
					last_q <= last_ptr;
					j_q    <= first_q;
					// reversed or equal pointers: empty row
					state_q <= (first_q < last_ptr) ? B_NZ : B_EMIT;
				end
				B_NZ: begin
					state_q <= B_NZW;
				end
				B_NZW: begin
					if (col_used) begin
						state_q <= B_VW;
					end else if (last_nz) begin
						state_q <= B_EMIT;
					end else begin
						j_q     <= j_q + PTR_W'(1);
						state_q <= B_NZ;
					end
				end
				B_VW: begin
					state_q <= B_MUL;
				end
				B_MUL: begin
					if (fpu_rsp.done) begin
						prod_q  <= fpu_rsp.result;
						state_q <= B_ADDS;
					end
				end
				B_ADDS: begin
					state_q <= B_ADD;
				end
				B_ADD: begin
					if (fpu_rsp.done) begin
						sum_q <= fpu_rsp.result;
						if (last_nz) begin
							state_q <= B_EMIT;
						end else begin
							j_q     <= j_q + PTR_W'(1);
							state_q <= B_NZ;
						end
					end
				end
				B_EMIT: begin
					if (!ov_q || rsp.ready) begin
						out_row_q  <= row_q;
						out_prod_q <= sum_q;
						state_q    <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.row         = out_row_q;
	assign rsp.row_product = out_prod_q;

	`CSM_ASSERT(a_pop_idle, q_pop |-> (state_q == B_IDLE), "queue popped while busy")
	`CSM_ASSERT_NEVER(a_fpu_overlap, fpu_start && fpu_rsp.busy, "fpu started while busy")
	`CSM_ASSERT(a_nz_in_row, (state_q == B_NZ) |-> (j_q < last_q), "nonzero read outside row")
endmodule

FILE: rtl/csr_sparse_matvec.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec
// A store write is carried out in the cycle that pops it from the queue head;
// pops wait while a compute is in progress. A compute runs longer for each
// used nonzero, set by the iterative multiply and add of csm_fpu; subnormals
// and cancellation add normalize steps (one or sixteen bit positions a cycle).
// Unused-row computes and out-of-range writes are dropped at the front. Reset
// is asynchronous: it empties the queue, idles both engines and sets row_count
// to 1; stores are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module csr_sparse_matvec import csm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	csm_req_if.sink   req,
	csm_cfg_if.sink   cfg,
	csm_rsp_if.source rsp
);
	logic            push;
	item_t           push_item;
	item_t           head;
	logic            q_empty;
	logic            q_full;
	logic            q_pop;
	logic [RC_W-1:0] row_count;

	csm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item),
		.row_count (row_count)
	);

	csm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	csm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.row_count (row_count),
		.rsp       (rsp)
	);
endmodule

FILE: verif/csr_sparse_matvec_test.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec_test
// Self-checking bench for the CSR sparse matrix-vector block. A short table
// covers reset state, range extremes, dropped writes and computes, saturated
// and reversed row pointers, and unused columns. Random phases follow. Each
// phase sets a row count, loads a small matrix and vector, then mixes
// computes, reloads and noise. A shadow copy of the stores predicts in IEEE
// double each row sum that the table does not give. Both sides throttle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module csr_sparse_matvec_test;
	import csm_pkg::*;

	localparam logic [63:0] D_ZERO = 64'h0000000000000000;
	localparam logic [63:0] D_ONE  = 64'h3FF0000000000000;
	localparam logic [63:0] D_TWO  = 64'h4000000000000000;
	localparam logic [63:0] D_NEG2 = 64'hC000000000000000;
	localparam logic [63:0] D_MAX  = 64'h7FEFFFFFFFFFFFFF;
	localparam logic [63:0] D_INF  = 64'h7FF0000000000000;
	localparam logic [63:0] D_TINY = 64'h0000000000000001;
	localparam int SETTLE_CYCLES = 200;
	localparam int LONG_HOLD     = 400;
	localparam int ITEM_TARGET   = 600;

	typedef struct {
		logic [ROW_W-1:0]   row;
		logic [VALUE_W-1:0] product;
	} row_result_t;

	typedef struct {
		bit                 is_cfg;
		logic [RC_W-1:0]    cfg_data;
		item_t              it;
		bit                 typed;
		logic [VALUE_W-1:0] typed_product;
	} dir_row_t;

	logic clk;
	logic arst_n;

	csm_req_if req ();
	csm_cfg_if cfg ();
	csm_rsp_if rsp ();

	csr_sparse_matvec dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.cfg    (cfg.sink),
		.rsp    (rsp.source)
	);

	// shadow stores and write flags
	logic [PTR_W-1:0]    ptr_mem [ROW_MAX+1];
	logic [COLUMN_W-1:0] col_mem [NONZERO_MAX];
	logic [VALUE_W-1:0]  mat_mem [NONZERO_MAX];
	logic [VALUE_W-1:0]  vec_mem [ROW_MAX];
	bit                  ptr_set [ROW_MAX+1];
	bit                  nz_set  [NONZERO_MAX];
	bit                  vec_set [ROW_MAX];
	int unsigned         rows_in_use;

	row_result_t pending_sums[$];
	dir_row_t    dir_rows[$];
	int          errors;
	int          items_sent;
	bit          quiet;
	bit          hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("csr_sparse_matvec regression: fail");
		$finish;
	end

	function automatic int unsigned clamp_nz(logic [PTR_W-1:0] p);
		return (p > NONZERO_MAX) ? NONZERO_MAX : p;
	endfunction

	function automatic logic [VALUE_W-1:0] row_sum(int unsigned r);
		real acc;
		real prod;
		int unsigned c;
		acc = 0.0;
		for (int unsigned j = clamp_nz(ptr_mem[r]); j < clamp_nz(ptr_mem[r+1]); j++) begin
			c = col_mem[j];
			if (c < rows_in_use) begin
				prod = $bitstoreal(mat_mem[j]) * $bitstoreal(vec_mem[c]);
				acc = acc + prod;
			end
		end
		return $realtobits(acc);
	endfunction

	// true when a compute of row r touches only written entries
	function automatic bit row_ready(int unsigned r);
		int unsigned c;
		if (r >= rows_in_use)
			return 1'b1;
		if (!ptr_set[r] || !ptr_set[r+1])
			return 1'b0;
		for (int unsigned j = clamp_nz(ptr_mem[r]); j < clamp_nz(ptr_mem[r+1]); j++) begin
			if (!nz_set[j])
				return 1'b0;
			c = col_mem[j];
			if (c < rows_in_use && !vec_set[c])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void apply_item(item_t it, bit typed, logic [VALUE_W-1:0] typed_p);
		row_result_t res;
		case (it.kind)
			KIND_ROW_PTR: if (it.index <= ROW_MAX) begin
				ptr_mem[it.index] = it.row_start;
				ptr_set[it.index] = 1'b1;
			end
			KIND_NONZERO: if (it.index < NONZERO_MAX) begin
				col_mem[it.index] = it.column;
				mat_mem[it.index] = it.value;
				nz_set[it.index]  = 1'b1;
			end
			KIND_VECTOR: if (it.index < ROW_MAX) begin
				vec_mem[it.index] = it.value;
				vec_set[it.index] = 1'b1;
			end
			default: if (it.index < rows_in_use) begin
				res.row = it.index[ROW_W-1:0];
				res.product = typed ? typed_p : row_sum(it.index);
				pending_sums.push_back(res);
			end
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] random_double();
		logic [VALUE_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 19))
			0: v[62:0] = '0;
			1: v[62:52] = '0;
			default: v[62:52] = 11'($urandom_range(900, 1150));
		endcase
		return v;
	endfunction

	task automatic send_item(item_t it, bit typed, logic [VALUE_W-1:0] typed_p);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			@(negedge clk) req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid     <= 1'b1;
		req.kind      <= it.kind;
		req.index     <= it.index;
		req.row_start <= it.row_start;
		req.column    <= it.column;
		req.value     <= it.value;
		do @(posedge clk); while (!req.ready);
		apply_item(it, typed, typed_p);
		items_sent++;
	endtask

	task automatic send_plain(kind_t k, int unsigned idx, int unsigned rs, int unsigned col,
			logic [VALUE_W-1:0] v);
		item_t it;
		it.kind = k;
		it.index = INDEX_W'(idx);
		it.row_start = ROW_START_W'(rs);
		it.column = COLUMN_W'(col);
		it.value = v;
		send_item(it, 1'b0, '0);
	endtask

	// wait out every expected sum, then let dropped items drain
	task automatic drain();
		@(negedge clk) req.valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_row_count(logic [RC_W-1:0] data);
		drain();
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		rows_in_use = (data == 0) ? 1 : (data > ROW_MAX) ? ROW_MAX : data;
		@(negedge clk) cfg.valid <= 1'b0;
	endtask

	task automatic add_row(bit is_cfg, logic [RC_W-1:0] cd, kind_t k, int unsigned idx,
			int unsigned rs, int unsigned col, logic [VALUE_W-1:0] v, bit typed,
			logic [VALUE_W-1:0] tp);
		dir_row_t d;
		d.is_cfg = is_cfg;
		d.cfg_data = cd;
		d.it.kind = k;
		d.it.index = INDEX_W'(idx);
		d.it.row_start = ROW_START_W'(rs);
		d.it.column = COLUMN_W'(col);
		d.it.value = v;
		d.typed = typed;
		d.typed_product = tp;
		dir_rows.push_back(d);
	endtask

	// result side: throttle, long hold on request, compare in order
	initial begin
		int stall;
		row_result_t want;
		rsp.ready = 1'b0;
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 6);
			if (hold_request) begin
				@(negedge clk) rsp.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
			end else if (stall > 0) begin
				@(negedge clk) rsp.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			if (pending_sums.size() == 0) begin
				$error("unexpected result row=%0d row_product=%h", rsp.row, rsp.row_product);
				errors++;
			end else begin
				want = pending_sums.pop_front();
				if (rsp.row !== want.row) begin
					$error("row: expected %0d, actual %0d", want.row, rsp.row);
					errors++;
				end
				if (rsp.row_product !== want.product) begin
					$error("row_product: expected %h, actual %h", want.product,
						rsp.row_product);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		int unsigned base;
		int unsigned pos;
		int unsigned r;
		int phase;
		errors = 0;
		items_sent = 0;
		quiet = 1'b0;
		hold_request = 1'b0;
		rows_in_use = 1;
		req.valid = 1'b0;
		req.kind = KIND_ROW_PTR;
		req.index = '0;
		req.row_start = '0;
		req.column = '0;
		req.value = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: row count starts at one
		add_row(0, 0, KIND_ROW_PTR, 0, 0, 0, D_ZERO, 0, 0);
		add_row(0, 0, KIND_ROW_PTR, 1, 0, 0, D_ZERO, 0, 0);
		add_row(0, 0, KIND_COMPUTE, 0, 0, 0, D_ZERO, 1, D_ZERO);
		add_row(0, 0, KIND_COMPUTE, 1, 0, 0, D_ZERO, 0, 0);
		add_row(0, 0, KIND_NONZERO, 0, 0, 0, D_ONE, 0, 0);
		add_row(0, 0, KIND_VECTOR, 0, 0, 0, D_TWO, 0, 0);
		add_row(0, 0, KIND_ROW_PTR, 1, 1, 0, D_ZERO, 0, 0);
		add_row(0, 0, KIND_COMPUTE, 0, 0, 0, D_ZERO, 1, D_TWO);
		add_row(0, 0, KIND_VECTOR, 0, 0, 0, D_MAX, 0, 0);
		add_row(0, 0, KIND_COMPUTE, 0, 0, 0, D_ZERO, 1, D_MAX);
		add_row(0, 0, KIND_NONZERO, 0, 0, 0, D_MAX, 0, 0);
		add_row(0, 0, KIND_COMPUTE, 0, 0, 0, D_ZERO, 1, D_INF);
		// column beyond the row count adds nothing
		add_row(0, 0, KIND_NONZERO, 0, 0, 1, D_MAX, 0, 0);
		add_row(0, 0, KIND_COMPUTE, 0, 0, 0, D_ZERO, 1, D_ZERO);
		add_row(0, 0, KIND_ROW_PTR, 4095, 8191, 0, D_ZERO, 0, 0);
		add_row(0, 0, KIND_VECTOR, 4095, 0, 0, {64{1'b1}}, 0, 0);
		add_row(0, 0, KIND_COMPUTE, 4095, 0, 0, D_ZERO, 0, 0);
		// oversize count saturates; top row with a saturated end pointer
		add_row(1, 11'h7FF, KIND_ROW_PTR, 0, 0, 0, D_ZERO, 0, 0);
		add_row(0, 0, KIND_NONZERO, 4095, 0, 1023, D_NEG2, 0, 0);
		add_row(0, 0, KIND_VECTOR, 1023, 0, 0, D_TINY, 0, 0);
		add_row(0, 0, KIND_ROW_PTR, 1023, 4095, 0, D_ZERO, 0, 0);
		add_row(0, 0, KIND_ROW_PTR, 1024, 8191, 0, D_ZERO, 0, 0);
		add_row(0, 0, KIND_COMPUTE, 1023, 0, 0, D_ZERO, 1, 64'h8000000000000002);
		// reversed pointers give an empty row
		add_row(0, 0, KIND_ROW_PTR, 1024, 0, 0, D_ZERO, 0, 0);
		add_row(0, 0, KIND_COMPUTE, 1023, 0, 0, D_ZERO, 1, D_ZERO);
		add_row(1, 11'd0, KIND_COMPUTE, 1023, 0, 0, D_ZERO, 0, 0);

		// a config row writes the count first, then sends its item
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_row_count(dir_rows[i].cfg_data);
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].typed_product);
		end

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			write_row_count(RC_W'(n));
			quiet = (phase == 2);
			base = $urandom_range(0, NONZERO_MAX - 8 * n - 1);
			pos = base;
			for (int i = 0; i <= n; i++) begin
				send_plain(KIND_ROW_PTR, i, pos, 0, '0);
				if (i < n)
					pos += $urandom_range(0, 5);
			end
			for (int unsigned j = base; j < pos; j++)
				send_plain(KIND_NONZERO, j, 0, $urandom_range(0, n + 1), random_double());
			for (int i = 0; i < n; i++)
				send_plain(KIND_VECTOR, i, 0, 0, random_double());
			if (phase == 1)
				hold_request = 1'b1;
			for (int k = 0; k < 25; k++) begin
				case ($urandom_range(0, 9))
					0, 1: send_plain(KIND_VECTOR, $urandom_range(0, n - 1), 0, 0, random_double());
					2: if (pos > base)
						send_plain(KIND_NONZERO, $urandom_range(base, pos - 1), 0,
							$urandom_range(0, n + 1), random_double());
					3: case ($urandom_range(0, 2))
						0: send_plain(KIND_ROW_PTR, $urandom_range(ROW_MAX + 1, 4095),
							$urandom, $urandom, {$urandom, $urandom});
						1: send_plain(KIND_VECTOR, $urandom_range(ROW_MAX, 4095), $urandom,
							$urandom, {$urandom, $urandom});
						default: send_plain(KIND_COMPUTE, $urandom_range(n, 4095), $urandom,
							$urandom, {$urandom, $urandom});
					endcase
					default: begin
						r = $urandom_range(0, n + 1);
						if (row_ready(r))
							send_plain(KIND_COMPUTE, r, $urandom, $urandom, {$urandom, $urandom});
					end
				endcase
			end
			quiet = 1'b0;
			phase++;
		end

		drain();
		if (errors == 0)
			$display("csr_sparse_matvec regression: pass");
		else
			$display("csr_sparse_matvec regression: fail");
		$finish;
	end
endmodule

FILE: csr_sparse_matvec.f
+incdir+rtl
rtl/csm_pkg.sv
rtl/csm_if.sv
rtl/csm_front.sv
rtl/csm_queue.sv
rtl/csm_fpu.sv
rtl/csm_back.sv
rtl/csr_sparse_matvec.sv
verif/csr_sparse_matvec_test.sv
